>>> sv/chi_square_distance_core_macros.svh
// Assertion macros for the chi-square distance core.
`ifndef CHI_SQUARE_DISTANCE_CORE_MACROS_SVH
`define CHI_SQUARE_DISTANCE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every clock edge outside reset.
`define CSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSD_ASSERT_NOW(label, ante, cons, msg)
`define CSD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> sv/csd_pkg.sv
// Shared constants and types of the chi-square distance core.
package csd_pkg;
  localparam int unsigned MAX_LEN   = 256;
  localparam int unsigned IDX_W     = $clog2(MAX_LEN + 1);
  localparam int unsigned ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned PROB_W    = 16;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned TOTAL_W   = 24;
  localparam int unsigned EXP_W     = PROB_W + TOTAL_W;   // expected count, Q.16
  localparam int unsigned SQ_W      = 2 * EXP_W;          // squared difference
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned DIV_STEPS = SUM_W / 2;          // radix-4 quotient digits
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  typedef struct packed {
    logic              start;
    logic [EXP_W-1:0]  den;
    logic [EXP_W-1:0]  rem;   // upper numerator bits, already below den
    logic [SUM_W-1:0]  num;   // lower numerator bits
  } csd_div_req_t;

  typedef struct packed {
    logic              done;
    logic [SUM_W-1:0]  quot;
  } csd_div_rsp_t;
endpackage

>>> sv/chi_square_distance_core.sv
// Top level of the chi-square distance core: buffer, sequencer, multiplier, divider, accumulator.
//
//  channel | direction | handshake         | beat payload
//  in_     | input     | in_valid/in_stall | expected_prob, observed_count, last_element
//  out_    | output    | out_valid/out_stall | chi_square, zero_expected, saturated,
//          |           |                   |   length_overflow
//
// A last beat starts a pass over the stored elements, which uses the shared 32x32
// multiplier (four uses per element with nonzero expected count) and the radix-4
// divider; a bin with zero expected count skips the squares and the divide, and a
// clipped term skips the divide. in_stall stays high from the last beat until the
// result beat is taken. Reset is synchronous, active low, and clears the sequencer,
// element count, total and flags; the buffer is not cleared. out_stall holds the
// result and keeps the block busy.
module chi_square_distance_core
  import csd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PROB_W-1:0]  in_expected_prob,
  input  logic [CNT_W-1:0]   in_observed_count,
  input  logic               in_last_element,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SUM_W-1:0]   out_chi_square,
  output logic               out_zero_expected,
  output logic               out_saturated,
  output logic               out_length_overflow
);
`include "chi_square_distance_core_macros.svh"

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_RD   = 11'b000_0000_0010,
    S_MULE = 11'b000_0000_0100,
    S_DIFF = 11'b000_0000_1000,
    S_SQ0  = 11'b000_0001_0000,
    S_SQ1  = 11'b000_0010_0000,
    S_SQ2  = 11'b000_0100_0000,
    S_CHK  = 11'b000_1000_0000,
    S_DIV  = 11'b001_0000_0000,
    S_ACC  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state_r;

  // element buffer: {prob, count}
  logic [PROB_W+CNT_W-1:0] mem [MAX_LEN];
  logic [PROB_W+CNT_W-1:0] rd_r;

  logic [IDX_W-1:0]   elem_idx_r;
  logic [IDX_W-1:0]   pass_i_r;
  logic [TOTAL_W-1:0] total_r;
  logic               ovf_r;
  logic               zero_r;
  logic               sat_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   term_r;
  logic [EXP_W-1:0]   e_r;
  logic [EXP_W-1:0]   mag_r;
  logic [SQ_W-1:0]    sq_r;

  logic               in_acc;
  logic               room;
  logic [TOTAL_W:0]   total_sum;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        prod;
  logic [EXP_W-1:0]   o_raw;
  logic               last_pass;
  logic               term_clip;
  logic [SUM_W:0]     acc_sum;
  csd_div_req_t       div_req;
  csd_div_rsp_t       div_rsp;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign room      = (elem_idx_r < IDX_W'(MAX_LEN));
  assign total_sum = {1'b0, total_r} + {{(TOTAL_W-CNT_W+1){1'b0}}, in_observed_count};
  assign o_raw     = {{(EXP_W-CNT_W-16){1'b0}}, rd_r[CNT_W-1:0], 16'b0};
  assign last_pass = ((pass_i_r + 1'b1) == elem_idx_r);
  assign term_clip = ({{(EXP_W-32){1'b0}}, sq_r[SQ_W-1 -: 32]} >= e_r);
  assign acc_sum   = {1'b0, sum_r} + {1'b0, term_r};

  // shared multiplier: expected count, then the three partial squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MULE: begin
        mul_a = {16'b0, rd_r[PROB_W+CNT_W-1:CNT_W]};
        mul_b = {8'b0, total_r};
      end
      S_SQ0: begin
        mul_a = mag_r[31:0];
        mul_b = mag_r[31:0];
      end
      S_SQ1: begin
        mul_a = {24'b0, mag_r[EXP_W-1:32]};
        mul_b = mag_r[31:0];
      end
      S_SQ2: begin
        mul_a = {24'b0, mag_r[EXP_W-1:32]};
        mul_b = {24'b0, mag_r[EXP_W-1:32]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    div_req.start = (state_r == S_CHK) && !term_clip;
    div_req.den   = e_r;
    div_req.rem   = {{(EXP_W-32){1'b0}}, sq_r[SQ_W-1 -: 32]};
    div_req.num   = sq_r[SUM_W-1:0];
  end

  csd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // buffer write on accept, registered read during the pass
  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      mem[elem_idx_r[ADDR_W-1:0]] <= {in_expected_prob, in_observed_count};
    end
    if (state_r == S_RD) begin
      rd_r <= mem[pass_i_r[ADDR_W-1:0]];
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      elem_idx_r <= '0;
      total_r    <= '0;
      ovf_r      <= 1'b0;
      pass_i_r   <= '0;
      zero_r     <= 1'b0;
      sat_r      <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (room) begin
              elem_idx_r <= elem_idx_r + 1'b1;
              total_r    <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_last_element) begin
              pass_i_r <= '0;
              zero_r   <= 1'b0;
              sat_r    <= 1'b0;
              state_r  <= S_RD;
            end
          end
        end
        S_RD:   state_r <= S_MULE;
        S_MULE: state_r <= S_DIFF;
        S_DIFF: begin
          // skip a bin whose expected count is zero
          if (e_r == '0) begin
            zero_r <= 1'b1;
            if (last_pass) begin
              state_r <= S_OUT;
            end else begin
              pass_i_r <= pass_i_r + 1'b1;
              state_r  <= S_RD;
            end
          end else begin
            state_r <= S_SQ0;
          end
        end
        S_SQ0: state_r <= S_SQ1;
        S_SQ1: state_r <= S_SQ2;
        S_SQ2: state_r <= S_CHK;
        S_CHK: begin
          if (term_clip) begin
            sat_r   <= 1'b1;
            state_r <= S_ACC;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (acc_sum[SUM_W]) begin
            sat_r <= 1'b1;
          end
          if (last_pass) begin
            state_r <= S_OUT;
          end else begin
            pass_i_r <= pass_i_r + 1'b1;
            state_r  <= S_RD;
          end
        end
        S_OUT: begin
          // drop the vector state once the result beat is taken
          if (!out_stall) begin
            elem_idx_r <= '0;
            total_r    <= '0;
            ovf_r      <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      sum_r <= '0;
    end
    if (state_r == S_MULE) begin
      e_r <= prod[EXP_W-1:0];
    end
    if (state_r == S_DIFF) begin
      mag_r <= (o_raw >= e_r) ? (o_raw - e_r) : (e_r - o_raw);
    end
    if (state_r == S_SQ0) begin
      sq_r <= {{(SQ_W-64){1'b0}}, prod};
    end
    if (state_r == S_SQ1) begin
      sq_r <= sq_r + ({{(SQ_W-64){1'b0}}, prod} << 33);
    end
    if (state_r == S_SQ2) begin
      sq_r <= sq_r + ({{(SQ_W-64){1'b0}}, prod} << 64);
    end
    if (state_r == S_CHK) begin
      term_r <= SUM_MAX;
    end
    if (state_r == S_DIV && div_rsp.done) begin
      term_r <= div_rsp.quot;
    end
    if (state_r == S_ACC) begin
      sum_r <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
    end
  end

  assign out_valid           = (state_r == S_OUT);
  assign out_chi_square      = sum_r;
  assign out_zero_expected   = zero_r;
  assign out_saturated       = sat_r;
  assign out_length_overflow = ovf_r;

  `CSD_ASSERT_NOW(a_idx_bound, 1'b1, elem_idx_r <= IDX_W'(MAX_LEN), "element count past buffer")
  `CSD_ASSERT_NOW(a_pass_in_range, state_r == S_RD, pass_i_r < elem_idx_r, "pass reads unwritten entry")
  `CSD_ASSERT_NEXT(a_div_to_acc, state_r == S_DIV && div_rsp.done, state_r == S_ACC, "divider result lost")
  `CSD_ASSERT_NEXT(a_chk_start, state_r == S_CHK && !term_clip, state_r == S_DIV, "divider not started")
endmodule

>>> sv/csd_div.sv
// Radix-4 restoring divider, two quotient bits per cycle.
module csd_div
  import csd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  csd_div_req_t req,
  output csd_div_rsp_t rsp
);
  logic [EXP_W-1:0]  den_r;
  logic [EXP_W+1:0]  den3_r;
  logic [EXP_W-1:0]  rem_r;
  logic [SUM_W-1:0]  num_r;
  logic [SUM_W-1:0]  q_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [EXP_W+1:0]  r4;
  logic [EXP_W+1:0]  den1;
  logic [EXP_W+1:0]  den2;
  logic [EXP_W+1:0]  diff;
  logic [1:0]        digit;

  always_comb begin
    r4   = {rem_r, num_r[SUM_W-1 -: 2]};
    den1 = {2'b00, den_r};
    den2 = {1'b0, den_r, 1'b0};
    if (r4 >= den3_r) begin
      digit = 2'd3;
      diff  = r4 - den3_r;
    end else if (r4 >= den2) begin
      digit = 2'd2;
      diff  = r4 - den2;
    end else if (r4 >= den1) begin
      digit = 2'd1;
      diff  = r4 - den1;
    end else begin
      digit = 2'd0;
      diff  = r4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r  <= req.den;
      den3_r <= {2'b00, req.den} + {1'b0, req.den, 1'b0};
      rem_r  <= req.rem;
      num_r  <= req.num;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= diff[EXP_W-1:0];
      num_r <= {num_r[SUM_W-3:0], 2'b00};
      q_r   <= {q_r[SUM_W-3:0], digit};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
endmodule
